/* hw/rtl/cdc_pkg.sv */
// ----------------------------------------------------------------------------
// Calendar date and time counter package
// Request and result payload types, request codes and the month length table.
// ----------------------------------------------------------------------------
package cdc_pkg;

	localparam int YEAR_BITS_DEF   = 16;
	localparam int YEAR_RESET      = 1970;
	localparam int YEAR_RESET_BITS = 12;

	localparam logic [3:0] REQ_INC_MIN   = 4'd0;
	localparam logic [3:0] REQ_INC_HOUR  = 4'd1;
	localparam logic [3:0] REQ_INC_DAY   = 4'd2;
	localparam logic [3:0] REQ_INC_MONTH = 4'd3;
	localparam logic [3:0] REQ_INC_YEAR  = 4'd4;
	localparam logic [3:0] REQ_DEC_MIN   = 4'd5;
	localparam logic [3:0] REQ_DEC_HOUR  = 4'd6;
	localparam logic [3:0] REQ_DEC_DAY   = 4'd7;
	localparam logic [3:0] REQ_DEC_MONTH = 4'd8;
	localparam logic [3:0] REQ_DEC_YEAR  = 4'd9;
	localparam logic [3:0] REQ_SET_MIN   = 4'd10;
	localparam logic [3:0] REQ_SET_HOUR  = 4'd11;
	localparam logic [3:0] REQ_SET_DAY   = 4'd12;
	localparam logic [3:0] REQ_SET_MONTH = 4'd13;
	localparam logic [3:0] REQ_SET_YEAR  = 4'd14;

	localparam logic [5:0] MINUTE_LAST = 6'd59;
	localparam logic [4:0] HOUR_LAST   = 5'd23;
	localparam logic [3:0] MONTH_LAST  = 4'd12;
	localparam logic [4:0] DAY_FIRST   = 5'd1;
	localparam logic [3:0] MONTH_FIRST = 4'd1;
	localparam logic [4:0] DAY_LAST    = 5'd31;

	localparam logic [4:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [3:0]        req_type;
		logic signed [15:0] set_value;
	} req_t;

	typedef struct packed {
		logic [5:0]         cur_minute;
		logic [4:0]         cur_hour;
		logic [4:0]         cur_day;
		logic [3:0]         cur_month;
		logic signed [15:0] cur_year;
		logic               rejected;
	} rsp_t;

	typedef struct packed {
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
	} stamp_t;

	function automatic int year_width(int bits);
		return (bits > YEAR_RESET_BITS) ? bits : YEAR_RESET_BITS;
	endfunction

	function automatic logic [4:0] month_len(logic [3:0] mo);
		if (mo < MONTH_FIRST || mo > MONTH_LAST) begin
			return DAY_LAST;
		end
		return MONTH_DAYS[mo - 4'd1];
	endfunction

endpackage

/* hw/rtl/calendar_datetime_counter.sv */
// ----------------------------------------------------------------------------
// Calendar date and time counter
// Holds minute, hour, day, month and year and applies one adjust request per
// transfer, returning the full date and time with a rejection flag.
//
// Requests arrive on the req channel and results leave on the rsp channel,
// both with valid and stall. Each accepted request gives exactly one result.
// A request is captured in an input register; once the result register is
// free, the next-state logic updates the stored date and loads the result
// register from it. One request is taken in every cycle while the rsp side
// keeps up; the update loop through the stored date and time sets the rate.
// When the receiver stalls, the result register holds its item, the captured
// request waits behind it, and req_stall rises only once both are full.
// Reset sets the date to 01/01/1970 00:00 and empties both registers.
// ----------------------------------------------------------------------------
module calendar_datetime_counter #(
	parameter int YEAR_BITS = cdc_pkg::YEAR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cdc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cdc_pkg::rsp_t rsp
);
	import cdc_pkg::*;

	localparam int YW = year_width(YEAR_BITS);
	localparam logic signed [YW-1:0] YEAR_INIT = YW'(YEAR_RESET);

	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_q;
	logic rsp_valid_q;
	stamp_t stamp_q, stamp_nxt;
	logic signed [YW-1:0] year_q, year_nxt;
	logic signed [YW+15:0] year_wide;
	logic rej_nxt;
	logic out_free, move;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign move      = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	cdc_next #(
		.YEAR_BITS(YEAR_BITS),
		.YW       (YW)
	) u_next (
		.req     (req_s1),
		.cur     (stamp_q),
		.cur_year(year_q),
		.nxt     (stamp_nxt),
		.nxt_year(year_nxt),
		.rejected(rej_nxt)
	);

	assign year_wide = (YW + 16)'(year_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			stamp_q     <= '{minute: 6'd0, hour: 5'd0, day: DAY_FIRST, month: MONTH_FIRST};
			year_q      <= YEAR_INIT;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
				stamp_q     <= stamp_nxt;
				year_q      <= year_nxt;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (move) begin
			rsp_q.cur_minute <= stamp_nxt.minute;
			rsp_q.cur_hour   <= stamp_nxt.hour;
			rsp_q.cur_day    <= stamp_nxt.day;
			rsp_q.cur_month  <= stamp_nxt.month;
			rsp_q.cur_year   <= year_wide[15:0];
			rsp_q.rejected   <= rej_nxt;
		end
	end

`ifndef SYNTHESIS
	a_stamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stamp_q.minute <= MINUTE_LAST) && (stamp_q.hour <= HOUR_LAST) &&
		(stamp_q.month >= MONTH_FIRST) && (stamp_q.month <= MONTH_LAST) &&
		(stamp_q.day >= DAY_FIRST) && (stamp_q.day <= DAY_LAST))
		else $error("stored date or time left its range");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(move && rej_nxt) |=> ($stable(stamp_q) && $stable(year_q)))
		else $error("rejected request changed the stored date");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && valid_s1))
		else $error("request stalled while a register was free");
`endif

endmodule

/* hw/rtl/cdc_next.sv */
// ----------------------------------------------------------------------------
// Calendar date and time counter next-state logic
// Applies one step, borrow or set request to the stored date and time.
// ----------------------------------------------------------------------------
module cdc_next #(
	parameter int YEAR_BITS = cdc_pkg::YEAR_BITS_DEF,
	parameter int YW        = cdc_pkg::year_width(YEAR_BITS)
) (
	input  cdc_pkg::req_t          req,
	input  cdc_pkg::stamp_t        cur,
	input  logic signed [YW-1:0]   cur_year,
	output cdc_pkg::stamp_t        nxt,
	output logic signed [YW-1:0]   nxt_year,
	output logic                   rejected
);
	import cdc_pkg::*;

	localparam int CW = ((YW > 16) ? YW : 16) + 1;
	localparam longint YMAX_L = (longint'(1) << (YEAR_BITS - 1)) - longint'(1);
	localparam logic signed [CW-1:0] YMAX = CW'(YMAX_L);
	localparam logic signed [CW-1:0] YMIN = CW'(-YMAX_L - longint'(1));

	logic [4:0] len_cur;
	logic inc_mi, inc_h, inc_d, inc_mo, inc_y;
	logic dec_mi, dec_h, dec_d, dec_mo, dec_y;
	logic c_mi, c_h, c_d, c_mo;
	logic b_mi, b_h, b_d, b_mo;
	stamp_t step;
	logic signed [CW-1:0] year_ext, year_sum, v_ext;
	logic year_ovf;
	logic [14:0] v_mag;
	logic v_neg;

	always_comb begin
		len_cur = month_len(cur.month);

		inc_mi = req.req_type == REQ_INC_MIN;
		c_mi   = inc_mi && (cur.minute >= MINUTE_LAST);
		inc_h  = (req.req_type == REQ_INC_HOUR) || c_mi;
		c_h    = inc_h && (cur.hour >= HOUR_LAST);
		inc_d  = (req.req_type == REQ_INC_DAY) || c_h;
		c_d    = inc_d && (cur.day >= len_cur);
		inc_mo = (req.req_type == REQ_INC_MONTH) || c_d;
		c_mo   = inc_mo && (cur.month >= MONTH_LAST);
		inc_y  = (req.req_type == REQ_INC_YEAR) || c_mo;

		dec_mi = req.req_type == REQ_DEC_MIN;
		b_mi   = dec_mi && (cur.minute == 6'd0);
		dec_h  = (req.req_type == REQ_DEC_HOUR) || b_mi;
		b_h    = dec_h && (cur.hour == 5'd0);
		dec_d  = (req.req_type == REQ_DEC_DAY) || b_h;
		b_d    = dec_d && (cur.day <= DAY_FIRST);
		dec_mo = (req.req_type == REQ_DEC_MONTH) || b_d;
		b_mo   = dec_mo && (cur.month <= MONTH_FIRST);
		dec_y  = (req.req_type == REQ_DEC_YEAR) || b_mo;

		step = cur;
		if (inc_mi) begin
			step.minute = c_mi ? 6'd0 : cur.minute + 6'd1;
		end else if (dec_mi) begin
			step.minute = b_mi ? MINUTE_LAST : cur.minute - 6'd1;
		end
		if (inc_h) begin
			step.hour = c_h ? 5'd0 : cur.hour + 5'd1;
		end else if (dec_h) begin
			step.hour = b_h ? HOUR_LAST : cur.hour - 5'd1;
		end
		if (inc_mo) begin
			step.month = c_mo ? MONTH_FIRST : cur.month + 4'd1;
		end else if (dec_mo) begin
			step.month = b_mo ? MONTH_LAST : cur.month - 4'd1;
		end
		if (inc_d) begin
			step.day = c_d ? DAY_FIRST : cur.day + 5'd1;
		end else if (dec_d) begin
			step.day = b_d ? month_len(step.month) : cur.day - 5'd1;
		end

		year_ext = CW'(cur_year);
		year_sum = year_ext + CW'(inc_y) - CW'(dec_y);
		year_ovf = (year_sum > YMAX) || (year_sum < YMIN);

		v_ext = CW'(req.set_value);
		v_neg = req.set_value[15];
		v_mag = req.set_value[14:0];

		nxt      = cur;
		nxt_year = cur_year;
		rejected = 1'b0;
		unique case (req.req_type)
			REQ_INC_MIN, REQ_INC_HOUR, REQ_INC_DAY, REQ_INC_MONTH, REQ_INC_YEAR,
			REQ_DEC_MIN, REQ_DEC_HOUR, REQ_DEC_DAY, REQ_DEC_MONTH, REQ_DEC_YEAR: begin
				if (year_ovf) begin
					rejected = 1'b1;
				end else begin
					nxt      = step;
					nxt_year = year_sum[YW-1:0];
				end
			end
			REQ_SET_MIN: begin
				if (!v_neg && v_mag <= 15'(MINUTE_LAST)) begin
					nxt.minute = req.set_value[5:0];
				end else begin
					rejected = 1'b1;
				end
			end
			REQ_SET_HOUR: begin
				if (!v_neg && v_mag <= 15'(HOUR_LAST)) begin
					nxt.hour = req.set_value[4:0];
				end else begin
					rejected = 1'b1;
				end
			end
			REQ_SET_DAY: begin
				if (!v_neg && v_mag != 15'd0 && v_mag <= 15'(len_cur)) begin
					nxt.day = req.set_value[4:0];
				end else begin
					rejected = 1'b1;
				end
			end
			REQ_SET_MONTH: begin
				if (!v_neg && v_mag != 15'd0 && v_mag <= 15'(MONTH_LAST)) begin
					nxt.month = req.set_value[3:0];
				end else begin
					rejected = 1'b1;
				end
			end
			REQ_SET_YEAR: begin
				if (v_ext >= YMIN && v_ext <= YMAX) begin
					nxt_year = v_ext[YW-1:0];
				end else begin
					rejected = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* sim/calendar_datetime_counter_test.sv */
// ----------------------------------------------------------------------------
// Calendar date and time counter testbench
// Drives adjust requests into the counter and checks every returned date and
// time against a predictor kept inside the bench. Directed sequences cover all
// request codes, rejected set values, rejected steps at both ends of the year
// range and month steps that leave the day beyond the month length. A random
// phase follows, first back to back and then with random gaps and stalls.
// ----------------------------------------------------------------------------
module calendar_datetime_counter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cdc_pkg::*;

	localparam int YEAR_BITS    = YEAR_BITS_DEF;
	localparam int YEAR_TOP     = (1 << (YEAR_BITS - 1)) - 1;
	localparam int YEAR_BOTTOM  = -(1 << (YEAR_BITS - 1));
	localparam int MINUTES      = 60;
	localparam int HOURS        = 24;
	localparam int MONTHS       = 12;
	localparam int LONGEST_DAY  = 31;
	localparam int IDLE_PERCENT = 32;
	localparam int STUCK_LIMIT  = 1000;

	localparam logic [3:0] REQ_UNUSED = 4'd15;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	bit   gaps_on      = 1'b0;
	int   errors       = 0;
	int   stuck_cycles = 0;
	rsp_t expected_stamps[$];

	int cal_minute;
	int cal_hour;
	int cal_day;
	int cal_month;
	int cal_year;

	calendar_datetime_counter #(
		.YEAR_BITS(YEAR_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int days_of(input int month);
		if (month < 1 || month > MONTHS) begin
			return LONGEST_DAY;
		end
		return int'(MONTH_DAYS[month - 1]);
	endfunction

	function automatic rsp_t next_stamp(input req_t item);
		int   mi;
		int   h;
		int   d;
		int   mo;
		int   y;
		int   v;
		logic carry;
		logic borrow;
		logic day_wrap;
		logic rej;
		rsp_t res;
		mi       = cal_minute;
		h        = cal_hour;
		d        = cal_day;
		mo       = cal_month;
		y        = cal_year;
		v        = item.set_value;
		carry    = 1'b0;
		borrow   = 1'b0;
		day_wrap = 1'b0;
		rej      = 1'b0;
		if (item.req_type <= REQ_DEC_YEAR) begin
			if (item.req_type == REQ_INC_MIN) begin
				mi++;
				if (mi >= MINUTES) begin
					mi    = 0;
					carry = 1'b1;
				end
			end
			if (item.req_type == REQ_INC_HOUR || carry) begin
				carry = 1'b0;
				h++;
				if (h >= HOURS) begin
					h     = 0;
					carry = 1'b1;
				end
			end
			if (item.req_type == REQ_INC_DAY || carry) begin
				carry = 1'b0;
				d++;
				if (d > days_of(mo)) begin
					d     = 1;
					carry = 1'b1;
				end
			end
			if (item.req_type == REQ_INC_MONTH || carry) begin
				carry = 1'b0;
				mo++;
				if (mo > MONTHS) begin
					mo    = 1;
					carry = 1'b1;
				end
			end
			if (item.req_type == REQ_INC_YEAR || carry) begin
				y++;
			end
			if (item.req_type == REQ_DEC_MIN) begin
				mi--;
				if (mi < 0) begin
					mi     = MINUTES - 1;
					borrow = 1'b1;
				end
			end
			if (item.req_type == REQ_DEC_HOUR || borrow) begin
				borrow = 1'b0;
				h--;
				if (h < 0) begin
					h      = HOURS - 1;
					borrow = 1'b1;
				end
			end
			if (item.req_type == REQ_DEC_DAY || borrow) begin
				borrow = 1'b0;
				d--;
				if (d < 1) begin
					day_wrap = 1'b1;
					borrow   = 1'b1;
				end
			end
			if (item.req_type == REQ_DEC_MONTH || borrow) begin
				borrow = 1'b0;
				mo--;
				if (mo < 1) begin
					mo     = MONTHS;
					borrow = 1'b1;
				end
			end
			if (item.req_type == REQ_DEC_YEAR || borrow) begin
				y--;
			end
			// A day borrow lands on the last day of the month reached.
			if (day_wrap) begin
				d = days_of(mo);
			end
			if (y > YEAR_TOP || y < YEAR_BOTTOM) begin
				rej = 1'b1;
			end else begin
				cal_minute = mi;
				cal_hour   = h;
				cal_day    = d;
				cal_month  = mo;
				cal_year   = y;
			end
		end else begin
			case (item.req_type)
				REQ_SET_MIN: begin
					if (v >= 0 && v < MINUTES) cal_minute = v;
					else rej = 1'b1;
				end
				REQ_SET_HOUR: begin
					if (v >= 0 && v < HOURS) cal_hour = v;
					else rej = 1'b1;
				end
				REQ_SET_DAY: begin
					if (v >= 1 && v <= days_of(cal_month)) cal_day = v;
					else rej = 1'b1;
				end
				REQ_SET_MONTH: begin
					if (v >= 1 && v <= MONTHS) cal_month = v;
					else rej = 1'b1;
				end
				REQ_SET_YEAR: begin
					if (v >= YEAR_BOTTOM && v <= YEAR_TOP) cal_year = v;
					else rej = 1'b1;
				end
				default: begin
				end
			endcase
		end
		res.cur_minute = cal_minute[5:0];
		res.cur_hour   = cal_hour[4:0];
		res.cur_day    = cal_day[4:0];
		res.cur_month  = cal_month[3:0];
		res.cur_year   = cal_year[15:0];
		res.rejected   = rej;
		return res;
	endfunction

	task automatic check_field(input string field, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		rsp_stall <= gaps_on && ($urandom_range(99) < IDLE_PERCENT);
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				expected_stamps.push_back(next_stamp(req));
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_stamps.size() == 0) begin
					$display("%0t: result %p arrived with no request outstanding", $time, rsp);
					errors++;
				end else begin
					want = expected_stamps.pop_front();
					check_field("cur_minute", want.cur_minute, rsp.cur_minute);
					check_field("cur_hour", want.cur_hour, rsp.cur_hour);
					check_field("cur_day", want.cur_day, rsp.cur_day);
					check_field("cur_month", want.cur_month, rsp.cur_month);
					check_field("cur_year", $signed(want.cur_year), $signed(rsp.cur_year));
					check_field("rejected", want.rejected, rsp.rejected);
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
		end
	end

	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
		$display("Verification failed");
		$finish;
	end

	task automatic send_request(input logic [3:0] code, input int value);
		req_t item;
		item.req_type  = code;
		item.set_value = value[15:0];
		while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_request_codes();
		for (int op = REQ_DEC_MIN; op <= REQ_DEC_YEAR; op++) begin
			send_request(4'(op), 0);
		end
		for (int op = REQ_INC_MIN; op <= REQ_INC_YEAR; op++) begin
			send_request(4'(op), 0);
		end
		send_request(REQ_UNUSED, -1);
	endtask

	task automatic test_year_bounds();
		send_request(REQ_SET_YEAR, YEAR_TOP);
		send_request(REQ_SET_MONTH, MONTHS);
		send_request(REQ_SET_DAY, LONGEST_DAY);
		send_request(REQ_SET_HOUR, HOURS - 1);
		send_request(REQ_SET_MIN, MINUTES - 1);
		send_request(REQ_INC_MIN, 0);
		send_request(REQ_SET_YEAR, YEAR_BOTTOM);
		send_request(REQ_INC_MIN, 0);
		send_request(REQ_DEC_YEAR, 0);
		send_request(REQ_DEC_MIN, 0);
		send_request(REQ_DEC_YEAR, 0);
	endtask

	task automatic test_set_range();
		send_request(REQ_SET_MIN, MINUTES);
		send_request(REQ_SET_MIN, -1);
		send_request(REQ_SET_HOUR, HOURS);
		send_request(REQ_SET_DAY, 0);
		send_request(REQ_SET_MONTH, MONTHS + 1);
		send_request(REQ_SET_MONTH, 0);
	endtask

	task automatic test_month_no_clamp();
		send_request(REQ_SET_DAY, LONGEST_DAY);
		send_request(REQ_INC_MONTH, 0);
		send_request(REQ_INC_DAY, 0);
		send_request(REQ_DEC_DAY, 0);
		send_request(REQ_SET_DAY, days_of(cal_month) + 1);
	endtask

	task automatic test_random_traffic(input int count, input bit idle);
		int         sent;
		int         pick;
		int         lo;
		int         hi;
		int         top;
		logic [3:0] op;
		gaps_on = idle;
		sent    = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				// Park next to one end of the year range, then step across it.
				top = $urandom_range(1);
				send_request(REQ_SET_YEAR,
					top ? YEAR_TOP - $urandom_range(1) : YEAR_BOTTOM + $urandom_range(1));
				send_request(REQ_SET_MONTH, top ? MONTHS : 1);
				send_request(REQ_SET_DAY, top ? LONGEST_DAY : 1);
				send_request(REQ_SET_HOUR, top ? HOURS - 1 : 0);
				send_request(REQ_SET_MIN, top ? MINUTES - 1 : 0);
				repeat (3) begin
					if (top) op = 4'($urandom_range(REQ_INC_YEAR, REQ_INC_MIN));
					else op = 4'($urandom_range(REQ_DEC_YEAR, REQ_DEC_MIN));
					send_request(op, $urandom);
				end
				sent += 8;
			end else if (pick < 60) begin
				send_request(4'($urandom_range(REQ_DEC_YEAR, REQ_INC_MIN)), $urandom);
				sent++;
			end else if (pick < 84) begin
				op = 4'($urandom_range(REQ_SET_YEAR, REQ_SET_MIN));
				case (op)
					REQ_SET_MIN: begin
						lo = 0;
						hi = MINUTES - 1;
					end
					REQ_SET_HOUR: begin
						lo = 0;
						hi = HOURS - 1;
					end
					REQ_SET_DAY: begin
						lo = 1;
						hi = days_of(cal_month);
					end
					REQ_SET_MONTH: begin
						lo = 1;
						hi = MONTHS;
					end
					default: begin
						lo = YEAR_BOTTOM;
						hi = YEAR_TOP;
					end
				endcase
				if ($urandom_range(3) == 0) send_request(op, $urandom_range(1) ? lo : hi);
				else send_request(op, lo + $urandom_range(hi - lo));
				sent++;
			end else if (pick < 96) begin
				send_request(4'($urandom_range(REQ_SET_YEAR, REQ_SET_MIN)), $urandom);
				sent++;
			end else begin
				send_request(REQ_UNUSED, $urandom);
				sent++;
			end
		end
	endtask

	initial begin
		cal_minute = 0;
		cal_hour   = 0;
		cal_day    = 1;
		cal_month  = 1;
		cal_year   = YEAR_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n  <= 1'b1;
		gaps_on = 1'b1;
		test_request_codes();
		test_year_bounds();
		test_set_range();
		test_month_no_clamp();
		test_random_traffic(300, 1'b0);
		test_random_traffic(650, 1'b1);
		req_valid <= 1'b0;
		while (expected_stamps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
